@@ src/json_string_field_extractor_defines.svh @@
// ----------------------------------------------------------------------------
// json_string_field_extractor_defines
// Assertion macros shared by the extractor RTL.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_FIELD_EXTRACTOR_DEFINES_SVH
`define JSON_STRING_FIELD_EXTRACTOR_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define JSFE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define JSFE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/jsfe_pkg.sv @@
// ----------------------------------------------------------------------------
// jsfe_pkg
// Types and constants of the JSON string field extractor.
// ----------------------------------------------------------------------------
package jsfe_pkg;

  // Key window sizing
  localparam int KEY_MAX   = 32;
  localparam int WIN_LEN   = KEY_MAX + 2;
  localparam int SEEN_W    = $clog2(WIN_LEN + 1);
  localparam int KEY_REGS  = 4;
  localparam int KEY_IDX_W = $clog2(KEY_REGS * 8);

  // Output buffer limit: capped at OUT_MAX and at 256
  localparam int OUT_MAX = 256;
  localparam int OUT_LIM = (OUT_MAX < 256) ? OUT_MAX : 256;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Characters
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Register indexes
  typedef enum logic [2:0] {
    CFG_KEY_LO     = 3'd0,
    CFG_KEY_MID_LO = 3'd1,
    CFG_KEY_MID_HI = 3'd2,
    CFG_KEY_HI     = 3'd3,
    CFG_KEY_LENGTH = 3'd4,
    CFG_OUT_SIZE   = 3'd5
  } cfg_reg_e;

  // Status codes
  typedef enum logic [2:0] {
    ST_FOUND      = 3'd0,
    ST_KEY_ABSENT = 3'd1,
    ST_NO_COLON   = 3'd2,
    ST_NO_QUOTE   = 3'd3,
    ST_ZERO_SIZE  = 3'd4
  } status_e;

  // Scan phase, one-hot
  typedef enum logic [4:0] {
    PH_SEARCH   = 5'b00001,
    PH_PRECOLON = 5'b00010,
    PH_PREQUOTE = 5'b00100,
    PH_VALUE    = 5'b01000,
    PH_DONE     = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] json_byte;
    logic       doc_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_status;
    logic [2:0] status;
    logic [7:0] value_length;
    logic       last;
  } out_item_t;

endpackage

@@ src/json_string_field_extractor.sv @@
// ----------------------------------------------------------------------------
// json_string_field_extractor
// Streams the string value of a configured JSON key out of a byte stream.
// ----------------------------------------------------------------------------
// Takes one document byte per cycle. Each byte is worked on in the cycle it is
// accepted: the quoted key is matched against a window of the newest bytes in
// one parallel compare, and the scan phase, escape flag and byte count advance
// at the same edge. A byte yields zero, one or two results (a value byte, a
// status, or both), which go into a four-entry result queue that the output
// drains one per cycle while out_ready_i is high. A byte is accepted whenever
// at least two queue slots are free, so the input runs at one byte per cycle
// as long as the output takes results as fast as they arrive. The user must
// write registers only while the block is idle; the block does not enforce
// this, and a write is taken in the cycle it is presented.
// ----------------------------------------------------------------------------
`include "json_string_field_extractor_defines.svh"

module json_string_field_extractor (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  // document bytes
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  jsfe_pkg::in_item_t  in_data_i,
  // results
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jsfe_pkg::out_item_t out_data_o
);

  // Configuration registers
  logic [63:0] key_q [jsfe_pkg::KEY_REGS];
  logic [5:0]  key_len_q;
  logic [8:0]  out_size_q;

  // Per-document state
  jsfe_pkg::phase_e              phase_q, phase_d;
  logic                          esc_q, esc_d;
  logic [7:0]                    emit_q, emit_d;
  logic [jsfe_pkg::SEEN_W-1:0]   seen_q, seen_d;
  logic [7:0]                    win_q [jsfe_pkg::WIN_LEN-1];
  logic                          win_shift;

  // Result queue
  jsfe_pkg::out_item_t           fifo_q [jsfe_pkg::FIFO_DEPTH];
  logic [jsfe_pkg::PTR_W-1:0]    rd_ptr_q, wr_ptr_q;
  logic [jsfe_pkg::CNT_W-1:0]    cnt_q;

  logic                          in_fire, out_fire;
  logic [1:0]                    n_res;
  jsfe_pkg::out_item_t           res0, res1;
  logic [8:0]                    lim;
  logic [5:0]                    len_eff;
  logic [255:0]                  key_vec;
  logic                          match;
  logic [7:0]                    b;

  // Build a status result
  function automatic jsfe_pkg::out_item_t status_item(jsfe_pkg::status_e code,
                                                      logic [7:0] cnt);
    jsfe_pkg::out_item_t r;
    r.out_byte     = 8'h00;
    r.is_status    = 1'b1;
    r.status       = code;
    r.value_length = (code == jsfe_pkg::ST_FOUND) ? cnt : 8'h00;
    r.last         = 1'b1;
    return r;
  endfunction

  // Status for a document that ends in the given phase
  function automatic jsfe_pkg::status_e end_code(jsfe_pkg::phase_e ph);
    jsfe_pkg::status_e c;
    unique case (ph)
      jsfe_pkg::PH_SEARCH:   c = jsfe_pkg::ST_KEY_ABSENT;
      jsfe_pkg::PH_PRECOLON: c = jsfe_pkg::ST_NO_COLON;
      jsfe_pkg::PH_PREQUOTE: c = jsfe_pkg::ST_NO_QUOTE;
      default:               c = jsfe_pkg::ST_FOUND;
    endcase
    return c;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return c == jsfe_pkg::CH_SPACE || c == jsfe_pkg::CH_TAB ||
           c == jsfe_pkg::CH_LF || c == jsfe_pkg::CH_CR;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = cnt_q <= jsfe_pkg::CNT_W'(jsfe_pkg::FIFO_DEPTH - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = fifo_q[rd_ptr_q];
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;
  assign b           = in_data_i.json_byte;

  // Effective limits
  assign lim = (out_size_q > 9'(jsfe_pkg::OUT_LIM)) ? 9'(jsfe_pkg::OUT_LIM) : out_size_q;
  assign len_eff = (key_len_q > 6'(jsfe_pkg::KEY_MAX)) ? 6'(jsfe_pkg::KEY_MAX) : key_len_q;
  assign key_vec = {key_q[3], key_q[2], key_q[1], key_q[0]};

  // Compare the window, shifted by the new byte, against the quoted key
  always_comb begin
    logic [jsfe_pkg::WIN_LEN-1:1]  ok;
    logic [jsfe_pkg::KEY_IDX_W-1:0] kidx;
    logic [jsfe_pkg::SEEN_W:0]     seen_new;
    ok   = '1;
    kidx = '0;
    for (int j = 1; j < jsfe_pkg::WIN_LEN; j++) begin
      kidx = jsfe_pkg::KEY_IDX_W'(int'(len_eff) - j);
      if (j == int'(len_eff) + 1) begin
        ok[j] = win_q[j-1] == jsfe_pkg::CH_QUOTE;
      end else if (j <= int'(len_eff)) begin
        ok[j] = win_q[j-1] == key_vec[{kidx, 3'b000} +: 8];
      end
    end
    seen_new = (seen_q < jsfe_pkg::SEEN_W'(jsfe_pkg::WIN_LEN)) ?
               {1'b0, seen_q} + 1'b1 : {1'b0, seen_q};
    match = (b == jsfe_pkg::CH_QUOTE) && (&ok) &&
            (seen_new >= (jsfe_pkg::SEEN_W+1)'(len_eff) + 2'd2);
  end

  // Advance the scan for one accepted byte
  always_comb begin
    logic [8:0] next_cnt;
    phase_d   = phase_q;
    esc_d     = esc_q;
    emit_d    = emit_q;
    seen_d    = seen_q;
    win_shift = 1'b0;
    n_res     = 2'd0;
    res0      = '0;
    res1      = '0;
    next_cnt  = {1'b0, emit_q} + 9'd1;
    if (in_fire) begin
      if (phase_q != jsfe_pkg::PH_DONE) begin
        if (lim == 9'd0) begin
          res0    = status_item(jsfe_pkg::ST_ZERO_SIZE, emit_q);
          n_res   = 2'd1;
          phase_d = jsfe_pkg::PH_DONE;
        end else if (b == jsfe_pkg::CH_NUL) begin
          res0    = status_item(end_code(phase_q), emit_q);
          n_res   = 2'd1;
          phase_d = jsfe_pkg::PH_DONE;
        end else begin
          unique case (phase_q)
            jsfe_pkg::PH_SEARCH: begin
              win_shift = 1'b1;
              seen_d = (seen_q < jsfe_pkg::SEEN_W'(jsfe_pkg::WIN_LEN)) ?
                       seen_q + 1'b1 : seen_q;
              if (match) phase_d = jsfe_pkg::PH_PRECOLON;
            end
            jsfe_pkg::PH_PRECOLON: begin
              if (b == jsfe_pkg::CH_COLON) begin
                phase_d = jsfe_pkg::PH_PREQUOTE;
              end else if (!is_ws(b)) begin
                res0    = status_item(jsfe_pkg::ST_NO_COLON, emit_q);
                n_res   = 2'd1;
                phase_d = jsfe_pkg::PH_DONE;
              end
            end
            jsfe_pkg::PH_PREQUOTE: begin
              if (b == jsfe_pkg::CH_QUOTE) begin
                phase_d = jsfe_pkg::PH_VALUE;
                if (next_cnt >= lim) begin
                  res0    = status_item(jsfe_pkg::ST_FOUND, emit_q);
                  n_res   = 2'd1;
                  phase_d = jsfe_pkg::PH_DONE;
                end
              end else if (!is_ws(b)) begin
                res0    = status_item(jsfe_pkg::ST_NO_QUOTE, emit_q);
                n_res   = 2'd1;
                phase_d = jsfe_pkg::PH_DONE;
              end
            end
            jsfe_pkg::PH_VALUE: begin
              if (!esc_q && b == jsfe_pkg::CH_BSLASH) begin
                esc_d = 1'b1;
              end else if (!esc_q && b == jsfe_pkg::CH_QUOTE) begin
                res0    = status_item(jsfe_pkg::ST_FOUND, emit_q);
                n_res   = 2'd1;
                phase_d = jsfe_pkg::PH_DONE;
              end else begin
                // emit a value byte, stop when the buffer is full
                esc_d          = 1'b0;
                res0.out_byte  = b;
                n_res          = 2'd1;
                emit_d         = next_cnt[7:0];
                if (next_cnt + 9'd1 >= lim) begin
                  res1    = status_item(jsfe_pkg::ST_FOUND, next_cnt[7:0]);
                  n_res   = 2'd2;
                  phase_d = jsfe_pkg::PH_DONE;
                end
              end
            end
            default: ;
          endcase
        end
        // close the document on its last byte
        if (in_data_i.doc_last && phase_d != jsfe_pkg::PH_DONE) begin
          if (n_res == 2'd0) begin
            res0 = status_item(end_code(phase_d), emit_d);
          end else begin
            res1 = status_item(end_code(phase_d), emit_d);
          end
          n_res   = n_res + 2'd1;
          phase_d = jsfe_pkg::PH_DONE;
        end
      end
      // drop per-document state after the last byte
      if (in_data_i.doc_last) begin
        phase_d = jsfe_pkg::PH_SEARCH;
        esc_d   = 1'b0;
        emit_d  = 8'h00;
        seen_d  = '0;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < jsfe_pkg::KEY_REGS; i++) key_q[i] <= '0;
      key_len_q  <= 6'd0;
      out_size_q <= 9'd256;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        jsfe_pkg::CFG_KEY_LO:     key_q[0]   <= cfg_data_i;
        jsfe_pkg::CFG_KEY_MID_LO: key_q[1]   <= cfg_data_i;
        jsfe_pkg::CFG_KEY_MID_HI: key_q[2]   <= cfg_data_i;
        jsfe_pkg::CFG_KEY_HI:     key_q[3]   <= cfg_data_i;
        jsfe_pkg::CFG_KEY_LENGTH: key_len_q  <= cfg_data_i[5:0];
        jsfe_pkg::CFG_OUT_SIZE:   out_size_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= jsfe_pkg::PH_SEARCH;
      esc_q   <= 1'b0;
      emit_q  <= 8'h00;
      seen_q  <= '0;
    end else begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      emit_q  <= emit_d;
      seen_q  <= seen_d;
    end
  end

  // Byte window, valid up to seen_q entries
  always_ff @(posedge clk_i) begin
    if (win_shift) begin
      win_q[0] <= b;
      for (int j = 1; j < jsfe_pkg::WIN_LEN - 1; j++) win_q[j] <= win_q[j-1];
    end
  end

  // Result queue pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_q + jsfe_pkg::PTR_W'(out_fire);
      wr_ptr_q <= wr_ptr_q + jsfe_pkg::PTR_W'(n_res);
      cnt_q    <= cnt_q + jsfe_pkg::CNT_W'(n_res) - jsfe_pkg::CNT_W'(out_fire);
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) fifo_q[wr_ptr_q] <= res0;
    if (n_res == 2'd2) fifo_q[wr_ptr_q + jsfe_pkg::PTR_W'(1)] <= res1;
  end

  // Assertions
  `JSFE_ASSERT(a_fifo_bound, cnt_q <= jsfe_pkg::CNT_W'(jsfe_pkg::FIFO_DEPTH), "result queue overflow")
  `JSFE_ASSERT(a_pair_order, n_res == 2'd2 |-> !res0.is_status && res1.is_status, "bad result pair")
  `JSFE_ASSERT(a_status_done, in_fire && !in_data_i.doc_last && n_res != 2'd0 && (res0.is_status || res1.is_status) |=> phase_q == jsfe_pkg::PH_DONE, "status without done phase")
  `JSFE_ASSERT(a_doc_clear, in_fire && in_data_i.doc_last |=> phase_q == jsfe_pkg::PH_SEARCH && seen_q == '0 && emit_q == 8'h00, "document state not cleared")
  `JSFE_ASSERT_ALWAYS(a_no_results_in_reset, !rst_ni |-> n_res == 2'd0 || !in_ready_o || in_valid_i, "push without input")

endmodule
